[sv/flcs_pkg.sv]
// ----------------------------------------------------------------------------
// Flash command sequencer package
// Shared types, command codes and bus-cycle slot tables for the sequencer.
// ----------------------------------------------------------------------------
package flcs_pkg;

    // default flash address width
    localparam int ADDR_WIDTH_DEF = 21;

    // fixed order of bus cycles a command may expand into
    localparam int NUM_SLOTS     = 14;
    localparam int SLOT_EXIT0    = 0;   // bypass exit, 0x90 at 0
    localparam int SLOT_EXIT1    = 1;   // bypass exit, 0x00 at 0
    localparam int SLOT_RST0     = 2;   // reset unlock, 0xAA
    localparam int SLOT_RST1     = 3;   // reset unlock, 0x55
    localparam int SLOT_RST2     = 4;   // reset command, 0xF0
    localparam int SLOT_UNL0     = 5;   // command unlock, 0xAA
    localparam int SLOT_UNL1     = 6;   // command unlock, 0x55
    localparam int SLOT_UNL2     = 7;   // command byte (variable)
    localparam int SLOT_BYP_PROG = 8;   // bypass program, 0xA0 at 0
    localparam int SLOT_ERS0     = 9;   // second erase unlock, 0xAA
    localparam int SLOT_ERS1     = 10;  // second erase unlock, 0x55
    localparam int SLOT_ERS2     = 11;  // erase confirm (variable)
    localparam int SLOT_PROG     = 12;  // program data write
    localparam int SLOT_FINAL    = 13;  // closing read or completion

    // unlock addresses and sector mask
    localparam logic [15:0] UNLOCK_A    = 16'h5555;
    localparam logic [15:0] UNLOCK_B    = 16'h2AAA;
    localparam logic [31:0] SECTOR_MASK = 32'h001F_E000;

    // command bytes
    localparam logic [7:0] CMD_UNLOCK1   = 8'hAA;
    localparam logic [7:0] CMD_UNLOCK2   = 8'h55;
    localparam logic [7:0] CMD_RESET     = 8'hF0;
    localparam logic [7:0] CMD_PROGRAM   = 8'hA0;
    localparam logic [7:0] CMD_BYPASS    = 8'h20;
    localparam logic [7:0] CMD_ERASE     = 8'h80;
    localparam logic [7:0] CMD_CHIP_ERS  = 8'h10;
    localparam logic [7:0] CMD_SECT_ERS  = 8'h30;
    localparam logic [7:0] CMD_AUTOSEL   = 8'h90;
    localparam logic [7:0] CMD_EXIT_DATA = 8'h00;

    // factory bytes of parts that support unlock bypass
    localparam logic [7:0] FACTORY_BYP_A = 8'h83;
    localparam logic [7:0] FACTORY_BYP_B = 8'h85;
    localparam logic [7:0] POLL_DONE     = 8'hFF;

    // fixed query addresses
    localparam logic [15:0] ADDR_MANUF   = 16'h0000;
    localparam logic [15:0] ADDR_DEVICE  = 16'h0001;
    localparam logic [15:0] ADDR_PROT    = 16'h0002;
    localparam logic [15:0] ADDR_FACTORY = 16'h0003;

    typedef enum logic [3:0] {
        OP_RESET        = 4'd0,
        OP_MANUF_ID     = 4'd1,
        OP_DEVICE_ID    = 4'd2,
        OP_FACTORY_PROT = 4'd3,
        OP_SECTOR_PROT  = 4'd4,
        OP_PROGRAM      = 4'd5,
        OP_UNLOCK_BYP   = 4'd6,
        OP_CHIP_ERASE   = 4'd7,
        OP_SECTOR_ERASE = 4'd8,
        OP_POLL_ERASE   = 4'd9,
        OP_TEST_BYPASS  = 4'd10,
        OP_READ         = 4'd11,
        OP_READ_RETURN  = 4'd12
    } op_t;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_DONE  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        MODE_READ   = 2'd0,
        MODE_AUTO   = 2'd1,
        MODE_BYPASS = 2'd2,
        MODE_ERASE  = 2'd3
    } dev_mode_t;

    typedef enum logic [2:0] {
        PEND_NONE = 3'd0,
        PEND_BYTE = 3'd1,
        PEND_PROT = 3'd2,
        PEND_POLL = 3'd3,
        PEND_TEST = 3'd4
    } pend_t;

    typedef logic [NUM_SLOTS-1:0] slot_mask_t;

    // expansion of one command: which slots run and their variable bytes
    typedef struct packed {
        slot_mask_t mask;
        logic [7:0] cmd3;
        logic [7:0] erase_data;
        logic [7:0] prog_data;
        kind_t      final_kind;
        logic       final_status;
        logic [7:0] final_answer;
    } plan_t;

    // tracked chip state (erase address travels apart, its width is a parameter)
    typedef struct packed {
        dev_mode_t  mode;
        logic       bypass_ok;
        pend_t      pend;
    } seq_state_t;

    // fixed address of a write slot
    function automatic logic [15:0] slot_addr(input int unsigned idx);
        logic [15:0] a;
        case (idx)
            SLOT_RST0, SLOT_RST2, SLOT_UNL0, SLOT_UNL2, SLOT_ERS0: a = UNLOCK_A;
            SLOT_RST1, SLOT_UNL1, SLOT_ERS1:                        a = UNLOCK_B;
            default:                                                a = 16'h0000;
        endcase
        return a;
    endfunction

    // fixed data of a write slot
    function automatic logic [7:0] slot_data(input int unsigned idx);
        logic [7:0] d;
        case (idx)
            SLOT_EXIT0:                      d = CMD_AUTOSEL;
            SLOT_RST0, SLOT_UNL0, SLOT_ERS0: d = CMD_UNLOCK1;
            SLOT_RST1, SLOT_UNL1, SLOT_ERS1: d = CMD_UNLOCK2;
            SLOT_RST2:                       d = CMD_RESET;
            SLOT_BYP_PROG:                   d = CMD_PROGRAM;
            default:                         d = CMD_EXIT_DATA;
        endcase
        return d;
    endfunction

endpackage

[sv/flash_command_sequencer.sv]
// ----------------------------------------------------------------------------
// Flash command sequencer
// Turns host requests for a parallel NOR flash into bus write/read beats with
// the 0x5555/0x2AAA unlock cycles and tracks chip mode, erase and bypass state.
//
//   channel  | dir | tdata (low bit up)                         | tuser | tlast
//   ---------+-----+--------------------------------------------+-------+------
//   s_axis   | in  | operation, address, value, zero pad        | -     | -
//   m_axis   | out | bus_address, bus_data, status, answer, pad | kind  | last
//
// A request is decoded in the cycle it is accepted; its beats follow from the
// plan register one per cycle while m_axis_tready is high, starting the next
// cycle, 1 to 12 beats. A request is taken while its predecessor's final beat
// is being accepted or when no beat is pending, so beats run back to back.
// Requests producing no beat (unknown operation, idle read return) are dropped.
// Reset clears the chip state and the plan; no clearing pass.
// Output stalls hold the current beat; input stays stalled until the last beat.
// ----------------------------------------------------------------------------
module flash_command_sequencer #(
    parameter int ADDR_WIDTH = flcs_pkg::ADDR_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // operation[3:0], address, value, zero pad
    input  logic [((ADDR_WIDTH+19)/8)*8-1:0]  s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // bus_address, bus_data, status, answer, zero pad
    output logic [((ADDR_WIDTH+24)/8)*8-1:0]  m_axis_tdata,
    // kind
    output flcs_pkg::kind_t                   m_axis_tuser,
    output logic                              m_axis_tlast
);
    import flcs_pkg::*;

    logic                  accept;
    logic [3:0]            in_op;
    logic [ADDR_WIDTH-1:0] in_addr;
    logic [7:0]            in_val;

    seq_state_t            state_reg;
    seq_state_t            state_next;
    logic [ADDR_WIDTH-1:0] erase_addr_reg;
    logic [ADDR_WIDTH-1:0] erase_addr_next;

    plan_t                 plan;
    logic [ADDR_WIDTH-1:0] ers3_addr;
    logic [ADDR_WIDTH-1:0] prog_addr;
    logic [ADDR_WIDTH-1:0] final_addr;

    // request fields
    assign in_op   = s_axis_tdata[3:0];
    assign in_addr = s_axis_tdata[ADDR_WIDTH+3:4];
    assign in_val  = s_axis_tdata[ADDR_WIDTH+11:ADDR_WIDTH+4];
    assign accept  = s_axis_tvalid && s_axis_tready;

    flcs_decode #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_decode (
        .op              (in_op),
        .addr            (in_addr),
        .val             (in_val),
        .st              (state_reg),
        .erase_addr      (erase_addr_reg),
        .plan            (plan),
        .ers3_addr       (ers3_addr),
        .prog_addr       (prog_addr),
        .final_addr      (final_addr),
        .st_next         (state_next),
        .erase_addr_next (erase_addr_next)
    );

    // chip state tracking, advanced per accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode      <= MODE_READ;
            state_reg.bypass_ok <= 1'b0;
            state_reg.pend      <= PEND_NONE;
            erase_addr_reg      <= '0;
        end
        else if (accept)
        begin
            state_reg      <= state_next;
            erase_addr_reg <= erase_addr_next;
        end
    end

    flcs_emit #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (accept),
        .plan          (plan),
        .ers3_addr     (ers3_addr),
        .prog_addr     (prog_addr),
        .final_addr    (final_addr),
        .free          (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

[sv/flcs_decode.sv]
// ----------------------------------------------------------------------------
// Flash command decoder
// Expands one host request into a slot plan and the next chip state.
// ----------------------------------------------------------------------------
module flcs_decode #(
    parameter int ADDR_WIDTH = flcs_pkg::ADDR_WIDTH_DEF
) (
    input  logic [3:0]            op,
    input  logic [ADDR_WIDTH-1:0] addr,
    input  logic [7:0]            val,
    input  flcs_pkg::seq_state_t  st,
    input  logic [ADDR_WIDTH-1:0] erase_addr,
    output flcs_pkg::plan_t       plan,
    output logic [ADDR_WIDTH-1:0] ers3_addr,
    output logic [ADDR_WIDTH-1:0] prog_addr,
    output logic [ADDR_WIDTH-1:0] final_addr,
    output flcs_pkg::seq_state_t  st_next,
    output logic [ADDR_WIDTH-1:0] erase_addr_next
);
    import flcs_pkg::*;

    localparam logic [ADDR_WIDTH-1:0] SECT_MASK = ADDR_WIDTH'(SECTOR_MASK);

    always_comb
    begin
        logic       do_rst;
        logic       do_unl;
        logic       do_ers;
        logic       bs;

        plan            = '0;
        plan.final_kind = KIND_DONE;
        plan.prog_data  = val;
        st_next         = st;
        erase_addr_next = erase_addr;
        ers3_addr       = ADDR_WIDTH'(UNLOCK_A);
        prog_addr       = addr;
        final_addr      = '0;
        do_rst          = 1'b0;
        do_unl          = 1'b0;
        do_ers          = 1'b0;
        bs              = 1'b0;

        if (op == OP_READ_RETURN)
        begin
            // interpret the byte returned by the outstanding read
            plan.mask[SLOT_FINAL] = 1'b1;
            st_next.pend          = PEND_NONE;
            case (st.pend)
                PEND_BYTE: plan.final_answer = val;
                PEND_PROT: plan.final_answer = {7'd0, (val != 8'd0)};
                PEND_POLL:
                begin
                    if (val == POLL_DONE)
                    begin
                        st_next.mode = MODE_READ;
                    end
                    plan.final_answer = {7'd0, (st_next.mode == MODE_ERASE)};
                end
                PEND_TEST:
                begin
                    bs                = (val == FACTORY_BYP_A) || (val == FACTORY_BYP_B);
                    st_next.bypass_ok = bs;
                    plan.final_answer = {7'd0, bs};
                end
                default:
                begin
                    // nothing pending: request is dropped
                    plan.mask    = '0;
                    st_next.pend = st.pend;
                end
            endcase
        end
        else if (op <= OP_READ)
        begin
            st_next.pend          = PEND_NONE;
            plan.mask[SLOT_FINAL] = 1'b1;
            if (op == OP_POLL_ERASE)
            begin
                if (st.mode == MODE_ERASE)
                begin
                    plan.final_kind = KIND_READ;
                    final_addr      = erase_addr;
                    st_next.pend    = PEND_POLL;
                end
            end
            else if (st.mode == MODE_ERASE)
            begin
                // busy erasing
                plan.final_status = 1'b1;
            end
            else
            begin
                case (op)
                    OP_RESET:
                    begin
                        do_rst       = 1'b1;
                        st_next.mode = MODE_READ;
                    end
                    OP_MANUF_ID, OP_DEVICE_ID, OP_FACTORY_PROT, OP_SECTOR_PROT,
                    OP_TEST_BYPASS:
                    begin
                        do_unl          = (st.mode != MODE_AUTO);
                        plan.cmd3       = CMD_AUTOSEL;
                        st_next.mode    = MODE_AUTO;
                        plan.final_kind = KIND_READ;
                        st_next.pend    = PEND_BYTE;
                        case (op)
                            OP_MANUF_ID:  final_addr = ADDR_WIDTH'(ADDR_MANUF);
                            OP_DEVICE_ID: final_addr = ADDR_WIDTH'(ADDR_DEVICE);
                            OP_SECTOR_PROT:
                            begin
                                final_addr   = (addr & SECT_MASK) | ADDR_WIDTH'(ADDR_PROT);
                                st_next.pend = PEND_PROT;
                            end
                            OP_TEST_BYPASS:
                            begin
                                final_addr   = ADDR_WIDTH'(ADDR_FACTORY);
                                st_next.pend = PEND_TEST;
                            end
                            default:      final_addr = ADDR_WIDTH'(ADDR_FACTORY);
                        endcase
                    end
                    OP_PROGRAM:
                    begin
                        // bypass programs with a single 0xA0 write, else a full unlock (reset first from autoselect)
                        do_rst = (st.mode == MODE_AUTO);
                        if (st.mode == MODE_BYPASS)
                        begin
                            plan.mask[SLOT_BYP_PROG] = 1'b1;
                        end
                        else
                        begin
                            do_unl       = 1'b1;
                            plan.cmd3    = CMD_PROGRAM;
                            st_next.mode = MODE_READ;
                        end
                        plan.mask[SLOT_PROG] = 1'b1;
                    end
                    OP_UNLOCK_BYP:
                    begin
                        if (st.bypass_ok)
                        begin
                            do_rst       = (st.mode != MODE_READ);
                            do_unl       = 1'b1;
                            plan.cmd3    = CMD_BYPASS;
                            st_next.mode = MODE_BYPASS;
                        end
                    end
                    OP_CHIP_ERASE, OP_SECTOR_ERASE:
                    begin
                        do_rst          = (st.mode != MODE_READ);
                        do_unl          = 1'b1;
                        do_ers          = 1'b1;
                        plan.cmd3       = CMD_ERASE;
                        st_next.mode    = MODE_ERASE;
                        if (op == OP_SECTOR_ERASE)
                        begin
                            erase_addr_next = addr;
                            ers3_addr       = addr & SECT_MASK;
                            plan.erase_data = CMD_SECT_ERS;
                        end
                        else
                        begin
                            erase_addr_next = '0;
                            plan.erase_data = CMD_CHIP_ERS;
                        end
                    end
                    default:
                    begin
                        // plain read
                        do_rst          = (st.mode != MODE_READ);
                        st_next.mode    = MODE_READ;
                        plan.final_kind = KIND_READ;
                        final_addr      = addr;
                        st_next.pend    = PEND_BYTE;
                    end
                endcase
            end
        end

        // common cycle groups
        if (do_rst)
        begin
            plan.mask[SLOT_RST0] = 1'b1;
            plan.mask[SLOT_RST1] = 1'b1;
            plan.mask[SLOT_RST2] = 1'b1;
            if (st.mode == MODE_BYPASS)
            begin
                plan.mask[SLOT_EXIT0] = 1'b1;
                plan.mask[SLOT_EXIT1] = 1'b1;
            end
        end
        if (do_unl)
        begin
            plan.mask[SLOT_UNL0] = 1'b1;
            plan.mask[SLOT_UNL1] = 1'b1;
            plan.mask[SLOT_UNL2] = 1'b1;
        end
        if (do_ers)
        begin
            plan.mask[SLOT_ERS0] = 1'b1;
            plan.mask[SLOT_ERS1] = 1'b1;
            plan.mask[SLOT_ERS2] = 1'b1;
        end
    end

endmodule

[sv/flcs_emit.sv]
// ----------------------------------------------------------------------------
// Flash bus-cycle emitter
// Holds one command plan and issues its enabled slots in order, one per beat.
// ----------------------------------------------------------------------------
module flcs_emit #(
    parameter int ADDR_WIDTH = flcs_pkg::ADDR_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              load,
    input  flcs_pkg::plan_t                   plan,
    input  logic [ADDR_WIDTH-1:0]             ers3_addr,
    input  logic [ADDR_WIDTH-1:0]             prog_addr,
    input  logic [ADDR_WIDTH-1:0]             final_addr,
    output logic                              free,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [((ADDR_WIDTH+24)/8)*8-1:0]  m_axis_tdata,
    output flcs_pkg::kind_t                   m_axis_tuser,
    output logic                              m_axis_tlast
);
    import flcs_pkg::*;

    localparam int OUT_W = ((ADDR_WIDTH + 24) / 8) * 8;

    localparam slot_mask_t FINAL_ONLY = slot_mask_t'(1) << SLOT_FINAL;

    slot_mask_t            mask_reg;
    slot_mask_t            mask_next;
    plan_t                 plan_reg;
    logic [ADDR_WIDTH-1:0] ers3_addr_reg;
    logic [ADDR_WIDTH-1:0] prog_addr_reg;
    logic [ADDR_WIDTH-1:0] final_addr_reg;

    slot_mask_t            sel;
    logic                  pop;
    logic [ADDR_WIDTH-1:0] out_addr;
    logic [7:0]            out_data;
    logic                  out_status;
    logic [7:0]            out_answer;

    // lowest pending slot is the current beat
    assign sel  = mask_reg & slot_mask_t'(~mask_reg + slot_mask_t'(1));
    assign pop  = m_axis_tvalid && m_axis_tready;
    assign free = (mask_reg == '0) || ((mask_reg == FINAL_ONLY) && m_axis_tready);

    // slot mask sequencing
    always_comb
    begin
        if (load)
        begin
            mask_next = plan.mask;
        end
        else if (pop)
        begin
            mask_next = mask_reg & ~sel;
        end
        else
        begin
            mask_next = mask_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else
        begin
            mask_reg <= mask_next;
        end
    end

    // plan payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            plan_reg       <= plan;
            ers3_addr_reg  <= ers3_addr;
            prog_addr_reg  <= prog_addr;
            final_addr_reg <= final_addr;
        end
    end

    // one-hot selection of the current slot's address and data
    always_comb
    begin
        logic [ADDR_WIDTH-1:0] a;
        logic [7:0]            d;
        out_addr = '0;
        out_data = '0;
        for (int unsigned i = 0; i < NUM_SLOTS; i++)
        begin
            a = ADDR_WIDTH'(slot_addr(i));
            d = slot_data(i);
            if (i == SLOT_UNL2)
            begin
                d = plan_reg.cmd3;
            end
            else if (i == SLOT_ERS2)
            begin
                a = ers3_addr_reg;
                d = plan_reg.erase_data;
            end
            else if (i == SLOT_PROG)
            begin
                a = prog_addr_reg;
                d = plan_reg.prog_data;
            end
            else if (i == SLOT_FINAL)
            begin
                a = final_addr_reg;
                d = '0;
            end
            out_addr = out_addr | ({ADDR_WIDTH{sel[i]}} & a);
            out_data = out_data | ({8{sel[i]}} & d);
        end
    end

    assign out_status    = sel[SLOT_FINAL] & plan_reg.final_status;
    assign out_answer    = {8{sel[SLOT_FINAL]}} & plan_reg.final_answer;
    assign m_axis_tvalid = (mask_reg != '0);
    assign m_axis_tlast  = sel[SLOT_FINAL];
    assign m_axis_tuser  = sel[SLOT_FINAL] ? plan_reg.final_kind : KIND_WRITE;
    assign m_axis_tdata  = OUT_W'({out_answer, out_status, out_data, out_addr});

    // every run closes with its final beat
    a_final_present: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> mask_reg[SLOT_FINAL])
        else $error("run without closing beat");

    // last beat means nothing else is queued
    a_last_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> $onehot(mask_reg))
        else $error("tlast with beats still queued");

    // a new plan only replaces an empty or draining run
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> ((mask_reg == '0) || (pop && m_axis_tlast)))
        else $error("plan loaded over a live run");

    // each accepted beat retires exactly one slot
    a_pop_one: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !load) |=> ($countones(mask_reg) == $countones($past(mask_reg)) - 1))
        else $error("beat retired wrong slot count");

endmodule
